>>> rtl/clt_pkg.sv
// Shared types and constants for the compacting list table.
// Used by clt_ctrl and compacting_list_table_top; no dependencies.
package clt_pkg;

  localparam int LIST_CAPACITY = 64;
  localparam int VALUE_WIDTH   = 32;
  localparam int IDX_W         = $clog2(LIST_CAPACITY);
  localparam int COUNT_W       = $clog2(LIST_CAPACITY + 1);

  localparam int OP_W     = 2;
  localparam int IN_VAL_W = 32;
  localparam int POS_W    = 6;
  localparam int RD_W     = 32;
  localparam int LEN_W    = 7;
  localparam int FOUND_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND       = 2'd0,
    OP_REMOVE_VALUE = 2'd1,
    OP_REMOVE_AT    = 2'd2,
    OP_READ_AT      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RDATA,
    ST_RESP
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [IN_VAL_W-1:0] value;
    logic [POS_W-1:0]    pos;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [RD_W-1:0]     read_value;
    logic [LEN_W-1:0]    list_length;
    logic [FOUND_W-1:0]  found_position;
  } res_t;

endpackage

>>> rtl/compacting_list_table_top.sv
// Top level of the compacting list table: request/result channels, output register.
// Depends on clt_pkg, clt_ctrl and clt_ram.
// Append and failed requests go straight to the result; read-at passes through a read-data state,
//   remove-at shifts the later entries, remove-by-value searches then shifts (one combined pass).
// Throughput: one request at a time; the next is taken once the result enters the output reg.
// Reset: synchronous, clears the entry count and the sequencer; the store is not cleared.
module compacting_list_table_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [clt_pkg::OP_W-1:0]       operation,
  input  logic [clt_pkg::IN_VAL_W-1:0]   item_value,
  input  logic [clt_pkg::POS_W-1:0]      position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [clt_pkg::RD_W-1:0]       read_value,
  output logic [clt_pkg::LEN_W-1:0]      list_length,
  output logic [clt_pkg::FOUND_W-1:0]    found_position
);

  localparam int VW = clt_pkg::VALUE_WIDTH;
  localparam int IW = clt_pkg::IDX_W;

  clt_pkg::req_t req;
  clt_pkg::res_t res, out_res;
  logic          idle, res_valid, slot_free, accept;
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;

  assign req.op    = clt_pkg::op_t'(operation);
  assign req.value = item_value;
  assign req.pos   = position;

  assign in_stall  = !idle;
  assign accept    = in_valid && idle;
  assign slot_free = !out_valid || !out_stall;

  clt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .slot_free (slot_free),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  clt_ram #(
    .WIDTH (clt_pkg::VALUE_WIDTH),
    .DEPTH (clt_pkg::LIST_CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_res <= res;
    end
  end

  assign status         = out_res.status;
  assign read_value     = out_res.read_value;
  assign list_length    = out_res.list_length;
  assign found_position = out_res.found_position;

endmodule

>>> rtl/clt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module clt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/clt_ctrl.sv
// Request sequencer for the compacting list table: search, shift and read passes.
// Depends on clt_pkg; drives the ports of one clt_ram instance.
module clt_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  clt_pkg::req_t                       req,
  input  logic                                slot_free,
  output logic                                idle,
  output logic                                res_valid,
  output clt_pkg::res_t                       res,
  output logic                                ram_we,
  output logic [clt_pkg::IDX_W-1:0]           ram_waddr,
  output logic [clt_pkg::VALUE_WIDTH-1:0]     ram_wdata,
  output logic                                ram_re,
  output logic [clt_pkg::IDX_W-1:0]           ram_raddr,
  input  logic [clt_pkg::VALUE_WIDTH-1:0]     ram_rdata
);

  localparam int VW  = clt_pkg::VALUE_WIDTH;
  localparam int IW  = clt_pkg::IDX_W;
  localparam int CW  = clt_pkg::COUNT_W;
  localparam int RW  = clt_pkg::RD_W;
  localparam int LW  = clt_pkg::LEN_W;
  localparam int FW  = clt_pkg::FOUND_W;

  clt_pkg::state_t  state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [IW-1:0]    idx, idx_next;
  logic [VW-1:0]    key, key_next;
  clt_pkg::status_t res_status, res_status_next;
  logic [VW-1:0]    res_read, res_read_next;
  logic [FW-1:0]    res_found, res_found_next;

  logic [CW-1:0] idx_p1, idx_p2;
  logic          pos_bad, pos_last, full;

  assign idx_p1   = CW'(idx) + CW'(1);
  assign idx_p2   = CW'(idx) + CW'(2);
  assign pos_bad  = int'(req.pos) >= int'(count);
  assign pos_last = int'(req.pos) + 1 >= int'(count);
  assign full     = count == CW'(clt_pkg::LIST_CAPACITY);

  assign idle      = state == clt_pkg::ST_IDLE;
  assign res_valid = state == clt_pkg::ST_RESP;
  assign res.status         = res_status;
  assign res.read_value     = RW'(res_read);
  assign res.list_length    = LW'(count);
  assign res.found_position = res_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clt_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_read   <= res_read_next;
    res_found  <= res_found_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    key_next        = key;
    res_status_next = res_status;
    res_read_next   = res_read;
    res_found_next  = res_found;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    case (state)
      clt_pkg::ST_IDLE: begin
        if (accept) begin
          key_next        = VW'(req.value);
          res_status_next = clt_pkg::STAT_DONE;
          res_read_next   = '0;
          res_found_next  = '0;
          state_next      = clt_pkg::ST_RESP;
          case (req.op)
            clt_pkg::OP_APPEND: begin
              if (full) begin
                res_status_next = clt_pkg::STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = IW'(count);
                ram_wdata  = VW'(req.value);
                count_next = count + CW'(1);
              end
            end
            clt_pkg::OP_REMOVE_VALUE: begin
              if (count == '0) begin
                res_status_next = clt_pkg::STAT_NOT_FOUND;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                idx_next   = '0;
                state_next = clt_pkg::ST_SEARCH;
              end
            end
            clt_pkg::OP_REMOVE_AT: begin
              if (pos_bad) begin
                res_status_next = clt_pkg::STAT_RANGE;
              end else if (pos_last) begin
                count_next = count - CW'(1);
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = IW'(req.pos) + IW'(1);
                idx_next   = IW'(req.pos);
                state_next = clt_pkg::ST_SHIFT;
              end
            end
            clt_pkg::OP_READ_AT: begin
              if (pos_bad) begin
                res_status_next = clt_pkg::STAT_RANGE;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = IW'(req.pos);
                state_next = clt_pkg::ST_RDATA;
              end
            end
            default: begin
              res_status_next = clt_pkg::STAT_DONE;
            end
          endcase
        end
      end
      clt_pkg::ST_SEARCH: begin
        ram_re    = 1'b1;
        ram_raddr = IW'(idx_p1);
        if (ram_rdata == key) begin
          res_found_next = FW'(idx);
          if (idx_p1 >= count) begin
            count_next = count - CW'(1);
            state_next = clt_pkg::ST_RESP;
          end else begin
            state_next = clt_pkg::ST_SHIFT;
          end
        end else if (idx_p1 >= count) begin
          res_status_next = clt_pkg::STAT_NOT_FOUND;
          state_next      = clt_pkg::ST_RESP;
        end else begin
          idx_next = IW'(idx_p1);
        end
      end
      clt_pkg::ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        idx_next  = IW'(idx_p1);
        if (idx_p2 < count) begin
          ram_re    = 1'b1;
          ram_raddr = IW'(idx_p2);
        end else begin
          count_next = count - CW'(1);
          state_next = clt_pkg::ST_RESP;
        end
      end
      clt_pkg::ST_RDATA: begin
        res_read_next = ram_rdata;
        state_next    = clt_pkg::ST_RESP;
      end
      clt_pkg::ST_RESP: begin
        if (slot_free) begin
          state_next = clt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = clt_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= clt_pkg::LIST_CAPACITY)
    else $error("entry count past capacity");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == clt_pkg::ST_IDLE || state == clt_pkg::ST_SHIFT))
    else $error("store written outside append or shift");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == clt_pkg::ST_SHIFT) |-> (idx_p1 < count))
    else $error("shift writes past the packed entries");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == clt_pkg::ST_RESP && !slot_free) |=> state == clt_pkg::ST_RESP)
    else $error("result dropped while output slot busy");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (state != clt_pkg::ST_IDLE && state != clt_pkg::ST_RESP) |=>
      (count == $past(count) || count == $past(count) - CW'(1)))
    else $error("count moved by more than one during a removal");
`endif

endmodule
